@@ hw/rtl/see_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package see_pkg;
    localparam int unsigned DataWidthDef = 32;
    localparam int unsigned FracBitsDef = 16;
    localparam int unsigned ScaleWidth = 31;
    localparam int unsigned CmdWidth = 2;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_NEIGH  = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_DIFF,
        OP_PROJ,
        OP_DIV_A,
        OP_DIV_B,
        OP_MAX,
        OP_ROOT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic step;
        logic start;
    } t_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sts;
endpackage
`default_nettype wire

@@ hw/rtl/see_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface see_in_if;
    import see_pkg::*;
    logic valid;
    logic ready;
    logic [CmdWidth-1:0] cmd;
    logic [ScaleWidth-1:0] scale_second;
    logic [ScaleWidth-1:0] scale_third;
    logic signed [31:0] short_axis_x, short_axis_y, short_axis_z;
    logic signed [31:0] long_axis_x, long_axis_y, long_axis_z;
    logic signed [31:0] pos_x, pos_y, pos_z;
    modport source(output valid, cmd, scale_second, scale_third, short_axis_x,
        short_axis_y, short_axis_z, long_axis_x, long_axis_y, long_axis_z,
        pos_x, pos_y, pos_z, input ready);
    modport sink(input valid, cmd, scale_second, scale_third, short_axis_x,
        short_axis_y, short_axis_z, long_axis_x, long_axis_y, long_axis_z,
        pos_x, pos_y, pos_z, output ready);
endinterface

interface see_out_if;
    import see_pkg::*;
    logic valid;
    logic ready;
    logic [ScaleWidth-1:0] semi_length;
    logic [ScaleWidth-1:0] aspect_ratio;
    logic signed [31:0] axis_out_x, axis_out_y, axis_out_z;
    modport source(output valid, semi_length, aspect_ratio, axis_out_x,
        axis_out_y, axis_out_z, input ready);
    modport sink(input valid, semi_length, aspect_ratio, axis_out_x,
        axis_out_y, axis_out_z, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/see_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module see_ctrl
    import see_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire t_cmd          i_cmd,
    output logic               o_ready,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output t_ctl               o_ctl,
    input  wire t_sts          i_sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_RATIO, S_RWAIT, S_LOADA, S_LOADB, S_DIFF, S_PROJ, S_DIVA,
        S_DIVB, S_MAX, S_ROOT, S_RTWAIT, S_OUT
    } t_state;

    t_state r_state, n_state;
    t_ctl   r_ctl, n_ctl;
    logic   r_out_valid, n_out_valid;

    assign o_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_ctl = r_ctl;

    always_comb begin
        n_state = r_state;
        n_ctl = '{op: r_ctl.op, step: 1'b0, start: 1'b0};
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    unique case (i_cmd)
                        CMD_BEGIN: begin
                            n_ctl = '{op: OP_LOAD, step: 1'b1, start: 1'b1};
                            n_state = S_RATIO;
                        end
                        CMD_NEIGH: begin
                            n_ctl = '{op: OP_DIFF, step: 1'b1, start: 1'b0};
                            n_state = S_PROJ;
                        end
                        CMD_FINISH: begin
                            n_ctl = '{op: OP_ROOT, step: 1'b1, start: 1'b1};
                            n_state = S_RTWAIT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RATIO: n_state = S_RWAIT;
            S_RWAIT: begin
                n_ctl.op = OP_LOAD;
                if (i_sts.done) begin
                    n_ctl.step = 1'b1;
                    n_state = S_LOADA;
                end
            end
            S_LOADA: begin
                n_ctl.step = 1'b1;
                n_state = S_LOADB;
            end
            S_LOADB: begin
                n_ctl.step = 1'b1;
                n_state = S_IDLE;
            end
            S_PROJ: begin
                n_ctl = '{op: OP_PROJ, step: 1'b1, start: 1'b0};
                n_state = S_DIVA;
            end
            S_DIVA: begin
                n_ctl = '{op: OP_DIV_A, step: 1'b0, start: 1'b1};
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_ctl.op = OP_DIV_A;
                if (i_sts.done) begin
                    n_ctl = '{op: OP_DIV_B, step: 1'b1, start: 1'b1};
                    n_state = S_DIVB;
                end
            end
            S_DIVB: begin
                if (i_sts.done) begin
                    n_ctl = '{op: OP_MAX, step: 1'b1, start: 1'b0};
                    n_state = S_MAX;
                end
            end
            S_MAX: begin
                n_ctl.op = OP_MAX;
                n_state = S_IDLE;
            end
            S_RTWAIT: begin
                if (i_sts.done) begin
                    n_ctl = '{op: OP_ROOT, step: 1'b1, start: 1'b0};
                    n_state = S_ROOT;
                end
            end
            S_ROOT: n_state = S_OUT;
            S_OUT: begin
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctl <= '{op: OP_IDLE, step: 1'b0, start: 1'b0};
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ctl <= n_ctl;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/see_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module see_datapath
    import see_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FracBitsDef
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctl                  i_ctl,
    output t_sts                       o_sts,
    input  wire logic [ScaleWidth-1:0] i_s2,
    input  wire logic [ScaleWidth-1:0] i_s3,
    input  wire logic signed [31:0]    i_sa [3],
    input  wire logic signed [31:0]    i_la [3],
    input  wire logic signed [31:0]    i_pos [3],
    output logic [ScaleWidth-1:0]      o_len,
    output logic [ScaleWidth-1:0]      o_ratio,
    output logic signed [31:0]         o_axis [3]
);
    localparam logic [63:0] Sat64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Sat31 = 64'h7FFF_FFFF;
    localparam logic [63:0] HalfQ = 64'd1 << (FRAC_BITS - 1);

    logic [63:0] r_base, r_ratio, r_a, r_b, r_max;
    logic signed [31:0] r_ctr [3], r_sd [3], r_ld [3], r_d [3];
    logic signed [31:0] r_x, r_y;
    logic [63:0] r_fa, r_len;
    logic [1:0]  r_phase;
    logic        r_done;

    // Shared unit: restoring division (128/64) or bitwise square root.
    logic [127:0] r_num;
    logic [63:0]  r_den, r_q;
    logic [129:0] r_rem;
    logic [7:0]   r_cnt;
    logic         r_busy, r_root;
    logic [129:0] n_rem;
    logic [129:0] trial;
    logic [63:0]  r_rt;

    function automatic logic signed [63:0] fl(input logic signed [63:0] p);
        fl = p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] cl(input logic signed [65:0] v);
        if (v > 66'sd2147483647) cl = 32'h7FFF_FFFF;
        else if (v < -66'sd2147483648) cl = 32'h8000_0000;
        else cl = v[31:0];
    endfunction

    // Scaled product built from two 32x32 partial products.
    function automatic logic [63:0] msat(input logic [63:0] x,
                                         input logic [31:0] y);
        logic [63:0]  p_lo;
        logic [63:0]  p_hi;
        logic [127:0] p;
        begin
            p_lo = {32'd0, x[31:0]} * {32'd0, y};
            p_hi = {32'd0, x[63:32]} * {32'd0, y};
            p = ({32'd0, p_hi, 32'd0} + {64'd0, p_lo}) >> FRAC_BITS;
            msat = (p > {64'd0, Sat64}) ? Sat64 : p[63:0];
        end
    endfunction

    function automatic logic [63:0] sq(input logic signed [31:0] v);
        logic [31:0] m;
        begin
            m = v[31] ? 32'(-v) : v;
            sq = {32'd0, m} * {32'd0, m};
        end
    endfunction

    always_comb begin
        if (r_root) begin
            n_rem = {r_rem[127:0], r_num[127:126]};
            trial = {64'd0, r_rt, 2'b01};
        end else begin
            n_rem = {r_rem[128:0], r_num[127]};
            trial = {66'd0, r_den};
        end
    end

    assign o_sts = '{busy: r_busy, done: r_done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_base <= '0;
            r_ratio <= HalfQ;
            r_a <= '0;
            r_b <= '0;
            r_max <= '0;
            r_phase <= '0;
            for (int i = 0; i < 3; i++) begin
                r_ctr[i] <= '0;
                r_sd[i] <= '0;
                r_ld[i] <= '0;
            end
        end else begin
            r_done <= r_busy && (r_cnt == 8'd1);
            if (r_busy) begin
                r_num <= r_root ? {r_num[125:0], 2'b00} : {r_num[126:0], 1'b0};
                if (n_rem >= trial) begin
                    r_rem <= n_rem - trial;
                    if (r_root) r_rt <= {r_rt[62:0], 1'b1};
                    else r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    if (r_root) r_rt <= {r_rt[62:0], 1'b0};
                    else r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_rem <= '0;
                r_q <= '0;
                r_rt <= '0;
                unique case (i_ctl.op)
                    OP_LOAD: begin
                        r_root <= 1'b0;
                        r_num <= {97'd0, i_s3} << FRAC_BITS;
                        r_den <= {33'd0, i_s2};
                        r_cnt <= 8'd128;
                        r_phase <= 2'd0;
                    end
                    OP_DIV_A: begin
                        r_root <= 1'b0;
                        r_num <= {64'd0, sq(r_x)};
                        r_den <= r_a;
                        r_cnt <= 8'd128;
                    end
                    OP_DIV_B: begin
                        r_root <= 1'b0;
                        r_num <= {64'd0, sq(r_y)};
                        r_den <= r_b;
                        r_cnt <= 8'd128;
                    end
                    OP_ROOT: begin
                        r_root <= 1'b1;
                        r_num <= {64'd0, r_max} << FRAC_BITS;
                        r_cnt <= 8'd64;
                    end
                    default: r_cnt <= 8'd1;
                endcase
            end
            if (i_ctl.step) begin
                unique case (i_ctl.op)
                    OP_LOAD: begin
                        if (i_ctl.start) begin
                            for (int i = 0; i < 3; i++) begin
                                r_sd[i] <= i_sa[i];
                                r_ld[i] <= i_la[i];
                                r_ctr[i] <= i_pos[i];
                            end
                            r_base <= {33'd0, i_s2};
                            r_max <= '0;
                        end else begin
                            // Ratio and a first, then b in two scaled products.
                            case (r_phase)
                                2'd0: begin
                                    logic [63:0] r;
                                    r = (r_den == 64'd0) ? Sat31 :
                                        ((r_q > Sat31) ? Sat31 : r_q);
                                    if (r < HalfQ) r = HalfQ;
                                    r_ratio <= r;
                                    r_a <= (r_base * r_base) >> FRAC_BITS;
                                end
                                2'd1: r_b <= msat(r_a, r_ratio[31:0]);
                                default: r_b <= msat(r_b, r_ratio[31:0]);
                            endcase
                            r_phase <= r_phase + 2'd1;
                        end
                    end
                    OP_DIFF: begin
                        for (int i = 0; i < 3; i++) begin
                            r_d[i] <= cl(66'(i_pos[i]) - 66'(r_ctr[i]));
                        end
                    end
                    OP_PROJ: begin
                        r_x <= cl(66'(fl(64'(r_d[0]) * 64'(r_ld[0])))
                                + 66'(fl(64'(r_d[1]) * 64'(r_ld[1])))
                                + 66'(fl(64'(r_d[2]) * 64'(r_ld[2]))));
                        r_y <= cl(66'(fl(64'(r_d[0]) * 64'(r_sd[0])))
                                + 66'(fl(64'(r_d[1]) * 64'(r_sd[1])))
                                + 66'(fl(64'(r_d[2]) * 64'(r_sd[2]))));
                    end
                    OP_DIV_B: begin
                        r_fa <= (r_den == 64'd0) ? ((r_rem != 0) ? Sat64 : 64'd0)
                                                 : r_q;
                    end
                    OP_MAX: begin
                        logic [64:0] f;
                        logic [63:0] fb;
                        fb = (r_den == 64'd0) ? ((r_rem != 0) ? Sat64 : 64'd0)
                                              : r_q;
                        f = {1'b0, r_fa} + {1'b0, fb};
                        if (f > {1'b0, Sat64}) f = {1'b0, Sat64};
                        if (f[63:0] > r_max) r_max <= f[63:0];
                    end
                    OP_ROOT: begin
                        if (!i_ctl.start) begin
                            logic [63:0] l;
                            l = msat(r_rt, r_base[31:0]);
                            r_len <= (l > Sat31) ? Sat31 : l;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_len = r_len[ScaleWidth-1:0];
    assign o_ratio = r_ratio[ScaleWidth-1:0];
    assign o_axis = r_ld;
endmodule
`default_nettype wire

@@ hw/rtl/splat_ellipse_extent_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Begin word: a 128-step ratio division, then three scaling steps.
// Neighbour word: projection, then two 128-step divisions in the shared divider.
// Finish word: a 64-step square root, after which the result is offered and held
// until taken; the next word is taken the cycle after it leaves.
// One word is worked at a time. Reset is synchronous and active low; it clears the
// controller and the stored axes, centre and scale, and sets the ratio to one half.
module splat_ellipse_extent_unit
    import see_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FracBitsDef
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    see_in_if.sink    i_in,
    see_out_if.source o_out
);
    t_ctl ctl;
    t_sts sts;
    logic [ScaleWidth-1:0] r_s2, r_s3;
    logic signed [31:0] r_sa [3], r_la [3], r_pos [3], ax [3];

    // The accepted word is held here, since the datapath acts on it in the cycle
    // after acceptance, and the source may already show the next word.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s2 <= i_in.scale_second;
            r_s3 <= i_in.scale_third;
            r_sa <= '{i_in.short_axis_x, i_in.short_axis_y, i_in.short_axis_z};
            r_la <= '{i_in.long_axis_x, i_in.long_axis_y, i_in.long_axis_z};
            r_pos <= '{i_in.pos_x, i_in.pos_y, i_in.pos_z};
        end
    end

    see_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in.valid), .i_cmd(t_cmd'(i_in.cmd)), .o_ready(i_in.ready),
        .i_out_ready(o_out.ready), .o_out_valid(o_out.valid),
        .o_ctl(ctl), .i_sts(sts)
    );

    see_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_s2(r_s2), .i_s3(r_s3),
        .i_sa(r_sa), .i_la(r_la), .i_pos(r_pos),
        .o_len(o_out.semi_length), .o_ratio(o_out.aspect_ratio), .o_axis(ax)
    );

    assign o_out.axis_out_x = ax[0];
    assign o_out.axis_out_y = ax[1];
    assign o_out.axis_out_z = ax[2];

    // A result word is never offered while a new word is accepted.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("ready while result pending");
    // A pending result holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid) else $error("result dropped");
endmodule
`default_nettype wire
